// ===== rtl/kcrl_pkg.sv =====
// ----------------------------------------------------------------------------
// kcrl_pkg
// shared widths, defaults and controller/datapath interface types for the
// keyed cooldown rate limiter
// ----------------------------------------------------------------------------
package kcrl_pkg;

  localparam int ENTRIES_DEF  = 16;
  localparam int KEY_BITS_DEF = 64;

  localparam int KEY_IN_W = 64;
  localparam int COOL_W   = 32;
  localparam int TIME_W   = 64;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // capture the input item, restart the scan
    logic step;      // advance the scan by one entry
    logic stamp_wr;  // refresh the stamp of the entry just compared
    logic insert;    // write key and time into the round-robin slot
    logic res_set;   // capture the decision
    logic res_val;
    logic out_load;  // move the decision into the output register
  } kcrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic trivial;   // empty key or zero cooldown
    logic match;     // compared entry is valid and holds the key
    logic cooling;   // stored stamp is within the cooldown
    logic last;      // compared entry is the final one
  } kcrl_sts_t;

endpackage

// ===== rtl/kcrl_ctrl.sv =====
// ----------------------------------------------------------------------------
// kcrl_ctrl
// sequencer: accepts an item, walks the table one entry a cycle, issues the
// table update and hands the decision to the output register
// ----------------------------------------------------------------------------
module kcrl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  kcrl_pkg::kcrl_sts_t sts,
  output kcrl_pkg::kcrl_cmd_t cmd
);
  import kcrl_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (sts.trivial) begin
          cmd.res_set = 1'b1;
          state_next  = ST_DONE;
        end else if (sts.match) begin
          cmd.res_set  = 1'b1;
          cmd.res_val  = sts.cooling;
          cmd.stamp_wr = !sts.cooling;
          state_next   = ST_DONE;
        end else if (sts.last) begin
          cmd.res_set = 1'b1;
          cmd.insert  = 1'b1;
          state_next  = ST_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/kcrl_dp.sv =====
// ----------------------------------------------------------------------------
// kcrl_dp
// datapath: item registers, key and stamp memories, valid bits, insert
// pointer, scan counter, compare logic and result register
// ----------------------------------------------------------------------------
module kcrl_dp #(
  parameter int ENTRIES  = kcrl_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = kcrl_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [kcrl_pkg::KEY_IN_W-1:0] event_key,
  input  logic [kcrl_pkg::COOL_W-1:0]   cooldown,
  input  logic [kcrl_pkg::TIME_W-1:0]   now_time,
  input  kcrl_pkg::kcrl_cmd_t           cmd,
  output kcrl_pkg::kcrl_sts_t           sts,
  output logic                          limited
);
  import kcrl_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

  logic [KEY_BITS-1:0] key_mem   [ENTRIES];
  logic [TIME_W-1:0]   stamp_mem [ENTRIES];
  logic [ENTRIES-1:0]  slot_valid;
  logic [IDX_W-1:0]    insert_pointer;

  logic [KEY_BITS-1:0] key_q;
  logic [COOL_W-1:0]   cool_q;
  logic [TIME_W-1:0]   now_q;

  logic [IDX_W-1:0]    rd_idx;
  logic [IDX_W-1:0]    cmp_idx;
  logic                cmp_vld;
  logic [KEY_BITS-1:0] key_rd;
  logic [TIME_W-1:0]   stamp_rd;
  logic                res_q;

  logic [TIME_W-1:0]   elapsed;
  logic                not_back;

  assign elapsed  = now_q - stamp_rd;
  assign not_back = (now_q >= stamp_rd);

  assign sts.trivial = (key_q == '0) || (cool_q == '0);
  assign sts.match   = cmp_vld && slot_valid[cmp_idx] && (key_rd == key_q);
  assign sts.cooling = not_back && (elapsed < {{(TIME_W-COOL_W){1'b0}}, cool_q});
  assign sts.last    = cmp_vld && (cmp_idx == IDX_LAST);

  // one read a cycle, compared in the cycle after
  always_ff @(posedge clk) begin
    key_rd   <= key_mem[rd_idx];
    stamp_rd <= stamp_mem[rd_idx];
    if (cmd.insert) begin
      key_mem[insert_pointer]   <= key_q;
      stamp_mem[insert_pointer] <= now_q;
    end else if (cmd.stamp_wr) begin
      stamp_mem[cmp_idx] <= now_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_q  <= event_key[KEY_BITS-1:0];
      cool_q <= cooldown;
      now_q  <= now_time;
    end
    if (cmd.res_set) begin
      res_q <= cmd.res_val;
    end
    if (cmd.out_load) begin
      limited <= res_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid     <= '0;
      insert_pointer <= '0;
      rd_idx         <= '0;
      cmp_idx        <= '0;
      cmp_vld        <= 1'b0;
    end else begin
      if (cmd.load) begin
        rd_idx  <= '0;
        cmp_vld <= 1'b0;
      end else if (cmd.step) begin
        rd_idx  <= (rd_idx == IDX_LAST) ? '0 : rd_idx + 1'b1;
        cmp_idx <= rd_idx;
        cmp_vld <= 1'b1;
      end
      if (cmd.insert) begin
        slot_valid[insert_pointer] <= 1'b1;
        insert_pointer <= (insert_pointer == IDX_LAST) ? '0 : insert_pointer + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/keyed_cooldown_rate_limiter.sv =====
// sequence per item: a table read, then a compare of each table entry in turn
// with the decision captured on a hit or on the last entry, then the result is
// presented; an empty key or a zero cooldown is decided before any compare
// no new item is accepted until the previous decision has moved into the output
// register, so a stalled result holds input
// reset: synchronous rst clears valid bits, insert pointer and control state
// ----------------------------------------------------------------------------
// keyed_cooldown_rate_limiter
// suppresses repeats of an event key that arrive within their cooldown,
// tracking recent keys in a small round-robin table
// ----------------------------------------------------------------------------
module keyed_cooldown_rate_limiter #(
  parameter int ENTRIES  = kcrl_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = kcrl_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [kcrl_pkg::KEY_IN_W-1:0] event_key,
  input  logic [kcrl_pkg::COOL_W-1:0]   cooldown,
  input  logic [kcrl_pkg::TIME_W-1:0]   now_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          limited
);
  import kcrl_pkg::*;

  kcrl_cmd_t cmd;
  kcrl_sts_t sts;

  kcrl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  kcrl_dp #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .event_key (event_key),
    .cooldown  (cooldown),
    .now_time  (now_time),
    .cmd       (cmd),
    .sts       (sts),
    .limited   (limited)
  );

endmodule

// ===== tb/keyed_cooldown_rate_limiter_checker.sv =====
// ----------------------------------------------------------------------------
// keyed_cooldown_rate_limiter_checker
// watches both channels of the limiter, keeps its own table of recent keys,
// works out the expected decision for every accepted item and compares it
// with each decision that leaves the block, in order
// ----------------------------------------------------------------------------
module keyed_cooldown_rate_limiter_checker #(
  parameter int ENTRIES  = kcrl_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = kcrl_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [kcrl_pkg::KEY_IN_W-1:0] event_key,
  input  logic [kcrl_pkg::COOL_W-1:0]   cooldown,
  input  logic [kcrl_pkg::TIME_W-1:0]   now_time,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          limited,
  output int                            fail_count,
  output int                            open_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import kcrl_pkg::*;

  localparam logic [KEY_IN_W-1:0] KEY_MASK = {KEY_IN_W{1'b1}} >> (KEY_IN_W - KEY_BITS);

  logic [KEY_IN_W-1:0] seen_key   [ENTRIES];
  logic [TIME_W-1:0]   seen_stamp [ENTRIES];
  logic                seen_valid [ENTRIES];
  int unsigned         fill_slot;
  bit                  owed_verdicts[$];

  // decision for one request, updating the local copy of the key table
  function automatic bit judge_request(input logic [KEY_IN_W-1:0] key_in,
                                       input logic [COOL_W-1:0]   cool,
                                       input logic [TIME_W-1:0]   stamp_now);
    logic [KEY_IN_W-1:0] key;
    key = key_in & KEY_MASK;
    if (key == '0 || cool == '0) return 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (seen_valid[i] && seen_key[i] == key) begin
        if (stamp_now >= seen_stamp[i] && stamp_now - seen_stamp[i] < TIME_W'(cool))
          return 1'b1;
        // expired or time went backwards: restart the cooldown from now
        seen_stamp[i] = stamp_now;
        return 1'b0;
      end
    end
    seen_key[fill_slot]   = key;
    seen_stamp[fill_slot] = stamp_now;
    seen_valid[fill_slot] = 1'b1;
    fill_slot = (fill_slot + 1) % ENTRIES;
    return 1'b0;
  endfunction

  always @(posedge clk) begin : watch
    bit want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        seen_key[i]   = '0;
        seen_stamp[i] = '0;
        seen_valid[i] = 1'b0;
      end
      fill_slot = 0;
      owed_verdicts.delete();
    end else begin
      // the leaving item is older than any item entering at the same edge
      if (out_valid && out_ready) begin
        if (owed_verdicts.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result, limited %0b with nothing outstanding",
                     $realtime, limited);
        end else begin
          want = owed_verdicts.pop_front();
          if (limited !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: limited expected %0b got %0b", $realtime, want, limited);
          end
        end
      end
      if (in_valid && in_ready)
        owed_verdicts.push_back(judge_request(event_key, cooldown, now_time));
    end
    open_count = owed_verdicts.size();
  end

endmodule

// ===== tb/keyed_cooldown_rate_limiter_tb.sv =====
// ----------------------------------------------------------------------------
// keyed_cooldown_rate_limiter_tb
// drives directed and random requests into the limiter with random gaps on
// both channels; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module keyed_cooldown_rate_limiter_tb;
  import kcrl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_POOL = 20;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [KEY_IN_W-1:0] event_key = '0;
  logic [COOL_W-1:0]   cooldown  = '0;
  logic [TIME_W-1:0]   now_time  = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                limited;
  int                  fail_count;
  int                  open_count;
  bit                  idle_on   = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  keyed_cooldown_rate_limiter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .event_key (event_key),
    .cooldown  (cooldown),
    .now_time  (now_time),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .limited   (limited)
  );

  keyed_cooldown_rate_limiter_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .event_key  (event_key),
    .cooldown   (cooldown),
    .now_time   (now_time),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .limited    (limited),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  always @(negedge clk) begin
    out_ready <= (idle_on && $urandom_range(0, 99) < 27) ? 1'b0 : 1'b1;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic offer(input logic [KEY_IN_W-1:0] key, input logic [COOL_W-1:0] cool,
                       input logic [TIME_W-1:0] stamp);
    while (idle_on && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    event_key <= key;
    cooldown  <= cool;
    now_time  <= stamp;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // hold the sender back until every decision has come out
  task automatic drain;
    in_valid <= 1'b0;
    do @(negedge clk); while (open_count != 0);
  endtask

  initial begin : stimulus
    logic [KEY_IN_W-1:0] key_pool [KEY_POOL];
    logic [KEY_IN_W-1:0] key;
    logic [COOL_W-1:0]   cool;
    logic [TIME_W-1:0]   clock_ms;
    int                  pick;

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    offer('0, 100, 10);                                  // empty key
    offer(5, 0, 10);                                     // zero cooldown
    offer(5, 100, 1000);                                 // first sighting
    offer(5, 100, 1050);
    offer(5, 100, 1099);                                 // one short of the cooldown
    offer(5, 100, 1100);                                 // exactly the cooldown
    offer(5, 100, 900);                                  // clock went backwards
    offer({KEY_IN_W{1'b1}}, {COOL_W{1'b1}}, '0);
    offer({KEY_IN_W{1'b1}}, {COOL_W{1'b1}}, {TIME_W{1'b1}});
    offer({1'b1, {(KEY_IN_W-1){1'b0}}}, 1, {TIME_W{1'b1}});
    offer({1'b1, {(KEY_IN_W-1){1'b0}}}, 1, {TIME_W{1'b1}});
    offer(5, {COOL_W{1'b1}}, '0);
    // wrap the insert pointer so the oldest key gets evicted
    for (int i = 1; i <= 14; i++) offer(64'h0123_4567_0000_0000 + i, 50, 2000);
    offer(5, 100, 2000);
    drain();

    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom} | 64'h1;
    clock_ms = 64'd5000;
    for (int n = 0; n < 1000; n++) begin
      idle_on = !(n >= 300 && n < 450);
      if (n % 200 == 199) drain();

      pick = $urandom_range(0, 99);
      if (pick < 4)      key = '0;
      else if (pick < 8) key = {$urandom, $urandom};
      else               key = key_pool[$urandom_range(0, KEY_POOL - 1)];

      pick = $urandom_range(0, 99);
      if (pick < 5)       cool = '0;
      else if (pick < 10) cool = $urandom;
      else                cool = $urandom_range(1, 60);

      pick = $urandom_range(0, 99);
      if (pick < 3)      clock_ms = {$urandom, $urandom};
      else if (pick < 8) clock_ms = clock_ms - $urandom_range(1, 100);
      else               clock_ms = clock_ms + $urandom_range(0, 25);

      offer(key, cool, clock_ms);
    end
    idle_on = 1'b1;
    drain();
    repeat (ENTRIES_DEF + 8) @(negedge clk);

    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/kcrl_pkg.sv
rtl/kcrl_ctrl.sv
rtl/kcrl_dp.sv
rtl/keyed_cooldown_rate_limiter.sv
tb/keyed_cooldown_rate_limiter_checker.sv
tb/keyed_cooldown_rate_limiter_tb.sv
